// ===== hw/rtl/excitation_walker_update_assert.svh =====
// Assertion macros for the excitation walker update block.
`ifndef EXCITATION_WALKER_UPDATE_ASSERT_SVH
`define EXCITATION_WALKER_UPDATE_ASSERT_SVH

// same-cycle implication
`define EWU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ewu assertion failed");

// next-cycle implication
`define EWU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ewu assertion failed");

`endif

// ===== hw/rtl/ewu_pkg.sv =====
// Shared types and constants for the excitation walker update block.
`timescale 1ns / 1ps

package ewu_pkg;

    localparam int MAX_ORBS   = 64;
    localparam int OCC_W      = MAX_ORBS;
    localparam int SO_W       = $clog2(2 * MAX_ORBS);
    localparam int TWO_N_W    = SO_W + 1;
    localparam int CODE_W     = 14;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = CODE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_ORBITAL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ALPHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_BETA    = 3'd4;

    typedef struct packed {
        logic              restart;
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] second_code;
    } ewu_in_t;

    typedef struct packed {
        logic [3:0]       exc_class;
        logic             class_invalid;
        logic             index_error;
        logic [CNT_W-1:0] hole_count;
        logic [CNT_W-1:0] virtual_count;
        logic [OCC_W-1:0] alpha_occupation;
        logic [OCC_W-1:0] beta_occupation;
    } ewu_out_t;

    typedef struct packed {
        logic            restart;
        logic            apply;
        logic [SO_W-1:0] src;
        logic [SO_W-1:0] dst;
    } ewu_cmd_t;

    typedef struct packed {
        logic [OCC_W-1:0] alpha;
        logic [OCC_W-1:0] beta;
        logic [CNT_W-1:0] hole_count;
        logic [CNT_W-1:0] virtual_count;
    } ewu_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESTART,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_CHECK,
        ST_APPLY1,
        ST_APPLY2,
        ST_FINISH
    } ewu_state_t;

endpackage

// ===== hw/rtl/excitation_walker_update.sv =====
// Top level of the excitation walker update block: config, sequencer, result register.
`timescale 1ns / 1ps

// Takes one item at a time and returns one result beat per item. For an excitation
// item, each of the two packed codes is split by one shared 14-step shift-subtract
// divider (one quotient bit per cycle), then the excitations are applied one per
// cycle. in_stall is high from accept until the result is loaded into the output
// register; a waiting result does not block the next accept.

module excitation_walker_update (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ewu_pkg::ewu_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ewu_pkg::ewu_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [ewu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ewu_pkg::OCC_W-1:0]       cfg_data
);

    ewu_pkg::ewu_state_t                state_reg, state_next;
    ewu_pkg::ewu_in_t                   item_reg, item_next;
    logic [ewu_pkg::SO_W-1:0]           src1_reg, src1_next, dst1_reg, dst1_next;
    logic [ewu_pkg::SO_W-1:0]           src2_reg, src2_next, dst2_reg, dst2_next;
    logic                               ovf1_reg, ovf1_next, ovf2_reg, ovf2_next;
    logic                               err_reg, err_next;
    logic                               out_valid_reg, out_valid_next;
    ewu_pkg::ewu_out_t                  out_data_reg, out_data_next;

    logic [ewu_pkg::CFG_W-1:0]          orbital_count_reg, core_count_reg, active_count_reg;
    logic [ewu_pkg::OCC_W-1:0]          start_alpha_reg, start_beta_reg;

    logic [ewu_pkg::CFG_W-1:0]          n_clamp;
    logic [ewu_pkg::TWO_N_W-1:0]        two_n;
    logic                               div_start, div_done;
    logic [ewu_pkg::CODE_W-1:0]         div_dividend, div_quotient;
    logic [ewu_pkg::TWO_N_W-1:0]        div_remainder;
    logic                               quo_ovf;
    ewu_pkg::ewu_cmd_t                  cmd;
    ewu_pkg::ewu_stat_t                 stat;
    logic                               second_live, cls_inval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbital_count_reg <= ewu_pkg::CFG_W'(ewu_pkg::MAX_ORBS);
            core_count_reg    <= '0;
            active_count_reg  <= ewu_pkg::CFG_W'(ewu_pkg::MAX_ORBS);
            start_alpha_reg   <= '0;
            start_beta_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ewu_pkg::REG_ORBITAL_COUNT: orbital_count_reg <= cfg_data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_CORE_COUNT:    core_count_reg    <= cfg_data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_ACTIVE_COUNT:  active_count_reg  <= cfg_data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_START_ALPHA:   start_alpha_reg   <= cfg_data;
                ewu_pkg::REG_START_BETA:    start_beta_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (orbital_count_reg == '0)
        begin
            n_clamp = ewu_pkg::CFG_W'(1);
        end
        else if (orbital_count_reg > ewu_pkg::CFG_W'(ewu_pkg::MAX_ORBS))
        begin
            n_clamp = ewu_pkg::CFG_W'(ewu_pkg::MAX_ORBS);
        end
        else
        begin
            n_clamp = orbital_count_reg;
        end
        two_n = {n_clamp, 1'b0};
    end

    ewu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (two_n),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    ewu_state u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .core_count   (core_count_reg),
        .active_count (active_count_reg),
        .start_alpha  (start_alpha_reg),
        .start_beta   (start_beta_reg),
        .stat         (stat)
    );

    assign quo_ovf     = div_quotient >= {{(ewu_pkg::CODE_W - ewu_pkg::TWO_N_W){1'b0}}, two_n};
    assign second_live = item_reg.second_code != '0;
    assign cls_inval   = (stat.hole_count > ewu_pkg::CNT_W'(2))
                         || (stat.virtual_count > ewu_pkg::CNT_W'(2));

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        src1_next      = src1_reg;
        dst1_next      = dst1_reg;
        src2_next      = src2_reg;
        dst2_next      = dst2_reg;
        ovf1_next      = ovf1_reg;
        ovf2_next      = ovf2_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        div_dividend   = item_reg.first_code;
        cmd            = '0;

        case (state_reg)
            ewu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = in_data.restart ? ewu_pkg::ST_RESTART : ewu_pkg::ST_START1;
                end
            end
            ewu_pkg::ST_RESTART:
            begin
                cmd.restart = 1'b1;
                err_next    = 1'b0;
                state_next  = ewu_pkg::ST_FINISH;
            end
            ewu_pkg::ST_START1:
            begin
                div_start  = 1'b1;
                state_next = ewu_pkg::ST_WAIT1;
            end
            ewu_pkg::ST_WAIT1:
            begin
                if (div_done)
                begin
                    src1_next  = div_quotient[ewu_pkg::SO_W-1:0];
                    dst1_next  = div_remainder[ewu_pkg::SO_W-1:0];
                    ovf1_next  = quo_ovf;
                    state_next = ewu_pkg::ST_START2;
                end
            end
            ewu_pkg::ST_START2:
            begin
                div_start    = 1'b1;
                div_dividend = item_reg.second_code;
                state_next   = ewu_pkg::ST_WAIT2;
            end
            ewu_pkg::ST_WAIT2:
            begin
                if (div_done)
                begin
                    src2_next  = div_quotient[ewu_pkg::SO_W-1:0];
                    dst2_next  = div_remainder[ewu_pkg::SO_W-1:0];
                    ovf2_next  = quo_ovf;
                    state_next = ewu_pkg::ST_CHECK;
                end
            end
            ewu_pkg::ST_CHECK:
            begin
                err_next   = ovf1_reg || (second_live && ovf2_reg);
                state_next = (ovf1_reg || (second_live && ovf2_reg))
                             ? ewu_pkg::ST_FINISH : ewu_pkg::ST_APPLY1;
            end
            ewu_pkg::ST_APPLY1:
            begin
                cmd.apply  = 1'b1;
                cmd.src    = src1_reg;
                cmd.dst    = dst1_reg;
                state_next = second_live ? ewu_pkg::ST_APPLY2 : ewu_pkg::ST_FINISH;
            end
            ewu_pkg::ST_APPLY2:
            begin
                cmd.apply  = 1'b1;
                cmd.src    = src2_reg;
                cmd.dst    = dst2_reg;
                state_next = ewu_pkg::ST_FINISH;
            end
            ewu_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.class_invalid    = cls_inval;
                    out_data_next.exc_class        = cls_inval ? 4'd0
                        : 4'(3 * stat.hole_count[1:0] + stat.virtual_count[1:0]);
                    out_data_next.index_error      = err_reg;
                    out_data_next.hole_count       = stat.hole_count;
                    out_data_next.virtual_count    = stat.virtual_count;
                    out_data_next.alpha_occupation = stat.alpha;
                    out_data_next.beta_occupation  = stat.beta;
                    state_next                     = ewu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ewu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        src1_reg     <= src1_next;
        dst1_reg     <= dst1_next;
        src2_reg     <= src2_next;
        dst2_reg     <= dst2_next;
        ovf1_reg     <= ovf1_next;
        ovf2_reg     <= ovf2_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = state_reg != ewu_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/ewu_div.sv =====
// Shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ewu_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ewu_pkg::CODE_W-1:0]     dividend,
    input  logic [ewu_pkg::TWO_N_W-1:0]    divisor,
    output logic                           done,
    output logic [ewu_pkg::CODE_W-1:0]     quotient,
    output logic [ewu_pkg::TWO_N_W-1:0]    remainder
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ewu_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ewu_pkg::CODE_W-1:0]        quo_reg, quo_next;
    logic [ewu_pkg::TWO_N_W-1:0]       rem_reg, rem_next;
    logic [ewu_pkg::TWO_N_W:0]         shifted;
    logic [ewu_pkg::TWO_N_W+1:0]       diff;

    assign shifted = {rem_reg, quo_reg[ewu_pkg::CODE_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[ewu_pkg::TWO_N_W+1])
            begin
                rem_next = diff[ewu_pkg::TWO_N_W-1:0];
                quo_next = {quo_reg[ewu_pkg::CODE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[ewu_pkg::TWO_N_W-1:0];
                quo_next = {quo_reg[ewu_pkg::CODE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ewu_pkg::DIV_CNT_W'(ewu_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/ewu_state.sv =====
// Determinant state: occupations, core-hole and virtual masks, and their counts.
`timescale 1ns / 1ps

module ewu_state (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ewu_pkg::ewu_cmd_t           cmd,
    input  logic [ewu_pkg::CFG_W-1:0]   core_count,
    input  logic [ewu_pkg::CFG_W-1:0]   active_count,
    input  logic [ewu_pkg::OCC_W-1:0]   start_alpha,
    input  logic [ewu_pkg::OCC_W-1:0]   start_beta,
    output ewu_pkg::ewu_stat_t          stat
);

    localparam int SO_N = 2 * ewu_pkg::MAX_ORBS;

    logic [ewu_pkg::OCC_W-1:0] alpha_reg, alpha_next;
    logic [ewu_pkg::OCC_W-1:0] beta_reg, beta_next;
    logic [SO_N-1:0]           hole_reg, hole_next;
    logic [SO_N-1:0]           virt_reg, virt_next;
    logic [ewu_pkg::CNT_W-1:0] hole_cnt_reg, hole_cnt_next;
    logic [ewu_pkg::CNT_W-1:0] virt_cnt_reg, virt_cnt_next;

    logic [ewu_pkg::CFG_W:0]   core_lim;
    logic [ewu_pkg::CFG_W+1:0] virt_lim;
    logic                      src_core, dst_core, src_virt, dst_virt;
    logic [SO_N-1:0]           src_bit, dst_bit, hole_mid, virt_mid;
    logic                      hole_add, hole_sub, virt_add, virt_sub;
    logic [ewu_pkg::OCC_W-1:0] occ_sel, occ_new;

    always_comb
    begin
        core_lim = {core_count, 1'b0};
        virt_lim = {({1'b0, core_count} + {1'b0, active_count}), 1'b0};
        src_core = {1'b0, cmd.src} < core_lim;
        dst_core = {1'b0, cmd.dst} < core_lim;
        src_virt = {2'b00, cmd.src} >= virt_lim;
        dst_virt = {2'b00, cmd.dst} >= virt_lim;
        src_bit  = SO_N'(1) << cmd.src;
        dst_bit  = SO_N'(1) << cmd.dst;

        hole_add = src_core && !hole_reg[cmd.src];
        hole_mid = src_core ? (hole_reg | src_bit) : hole_reg;
        hole_sub = dst_core && hole_mid[cmd.dst];

        virt_sub = src_virt && virt_reg[cmd.src];
        virt_mid = src_virt ? (virt_reg & ~src_bit) : virt_reg;
        virt_add = dst_virt && !virt_mid[cmd.dst];

        occ_sel = cmd.src[0] ? beta_reg : alpha_reg;
        occ_new = (occ_sel & ~(ewu_pkg::OCC_W'(1) << cmd.src[ewu_pkg::SO_W-1:1]))
                  | (ewu_pkg::OCC_W'(1) << cmd.dst[ewu_pkg::SO_W-1:1]);

        alpha_next    = alpha_reg;
        beta_next     = beta_reg;
        hole_next     = hole_reg;
        virt_next     = virt_reg;
        hole_cnt_next = hole_cnt_reg;
        virt_cnt_next = virt_cnt_reg;

        if (cmd.restart)
        begin
            alpha_next    = start_alpha;
            beta_next     = start_beta;
            hole_next     = '0;
            virt_next     = '0;
            hole_cnt_next = '0;
            virt_cnt_next = '0;
        end
        else if (cmd.apply)
        begin
            hole_next     = dst_core ? (hole_mid & ~dst_bit) : hole_mid;
            virt_next     = dst_virt ? (virt_mid | dst_bit) : virt_mid;
            hole_cnt_next = hole_cnt_reg + ewu_pkg::CNT_W'(hole_add)
                            - ewu_pkg::CNT_W'(hole_sub);
            virt_cnt_next = virt_cnt_reg + ewu_pkg::CNT_W'(virt_add)
                            - ewu_pkg::CNT_W'(virt_sub);
            if (cmd.src[0])
            begin
                beta_next = occ_new;
            end
            else
            begin
                alpha_next = occ_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= '0;
            beta_reg     <= '0;
            hole_reg     <= '0;
            virt_reg     <= '0;
            hole_cnt_reg <= '0;
            virt_cnt_reg <= '0;
        end
        else
        begin
            alpha_reg    <= alpha_next;
            beta_reg     <= beta_next;
            hole_reg     <= hole_next;
            virt_reg     <= virt_next;
            hole_cnt_reg <= hole_cnt_next;
            virt_cnt_reg <= virt_cnt_next;
        end
    end

    assign stat.alpha         = alpha_reg;
    assign stat.beta          = beta_reg;
    assign stat.hole_count    = hole_cnt_reg;
    assign stat.virtual_count = virt_cnt_reg;

endmodule

// ===== hw/rtl/ewu_checker.sv =====
// Port-level checker for the excitation walker update block, with its bind.
`timescale 1ns / 1ps
`include "excitation_walker_update_assert.svh"

module ewu_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  ewu_pkg::ewu_out_t               out_data
);

    logic       invalid_want;
    logic [3:0] class_want;

    assign invalid_want = (out_data.hole_count > 8'd2) || (out_data.virtual_count > 8'd2);
    assign class_want   = out_data.class_invalid ? 4'd0
                          : 4'(3 * out_data.hole_count + out_data.virtual_count);

    `EWU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `EWU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `EWU_ASSERT_IMPLY(a_invalid_flag, clk, rst_n, out_valid, out_data.class_invalid == invalid_want)
    `EWU_ASSERT_IMPLY(a_class_value, clk, rst_n, out_valid, out_data.exc_class == class_want)

endmodule

bind excitation_walker_update ewu_checker u_ewu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== bench/excitation_walker_update_tb.sv =====
// Testbench for excitation_walker_update: scoreboard prediction of occupations, masks and class.
`timescale 1ns / 1ps

module excitation_walker_update_tb;

    class walker_scoreboard;
        logic [ewu_pkg::CFG_W-1:0] orbital_count;
        logic [ewu_pkg::CFG_W-1:0] core_count;
        logic [ewu_pkg::CFG_W-1:0] active_count;
        logic [ewu_pkg::OCC_W-1:0] load_alpha;
        logic [ewu_pkg::OCC_W-1:0] load_beta;
        logic [ewu_pkg::OCC_W-1:0] alpha;
        logic [ewu_pkg::OCC_W-1:0] beta;
        logic [2*ewu_pkg::MAX_ORBS-1:0] hole_mask;
        logic [2*ewu_pkg::MAX_ORBS-1:0] fill_mask;
        ewu_pkg::ewu_out_t expected_q[$];
        int errors;
        int items;
        int restarts;
        int index_errors;
        int invalid_classes;
        int checked;
        bit [8:0] classes_seen;

        function new();
            orbital_count = ewu_pkg::CFG_W'(64);
            core_count = '0;
            active_count = ewu_pkg::CFG_W'(64);
            load_alpha = '0;
            load_beta = '0;
            alpha = '0;
            beta = '0;
            hole_mask = '0;
            fill_mask = '0;
            errors = 0;
            items = 0;
            restarts = 0;
            index_errors = 0;
            invalid_classes = 0;
            checked = 0;
            classes_seen = '0;
        endfunction

        function void write_reg(logic [ewu_pkg::CFG_IDX_W-1:0] idx,
                                logic [ewu_pkg::OCC_W-1:0] data);
            case (idx)
                ewu_pkg::REG_ORBITAL_COUNT: orbital_count = data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_CORE_COUNT:    core_count = data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_ACTIVE_COUNT:  active_count = data[ewu_pkg::CFG_W-1:0];
                ewu_pkg::REG_START_ALPHA:   load_alpha = data;
                ewu_pkg::REG_START_BETA:    load_beta = data;
                default: ;
            endcase
        endfunction

        function int unsigned two_n();
            int unsigned n;
            n = 32'(orbital_count);
            if (n < 1) n = 1;
            if (n > ewu_pkg::MAX_ORBS) n = ewu_pkg::MAX_ORBS;
            return 2 * n;
        endfunction

        function void move_electron(int unsigned src, int unsigned dst);
            int unsigned core_lim;
            int unsigned virt_lim;
            core_lim = 2 * 32'(core_count);
            virt_lim = 2 * (32'(core_count) + 32'(active_count));
            if (src < core_lim) hole_mask[7'(src)] = 1'b1;
            if (dst < core_lim) hole_mask[7'(dst)] = 1'b0;
            if (src >= virt_lim) fill_mask[7'(src)] = 1'b0;
            if (dst >= virt_lim) fill_mask[7'(dst)] = 1'b1;
            if (src[0])
            begin
                beta[6'(src >> 1)] = 1'b0;
                beta[6'(dst >> 1)] = 1'b1;
            end
            else
            begin
                alpha[6'(src >> 1)] = 1'b0;
                alpha[6'(dst >> 1)] = 1'b1;
            end
        endfunction

        function void note_item(ewu_pkg::ewu_in_t item);
            int unsigned tn;
            int unsigned c1;
            int unsigned c2;
            int unsigned i1;
            int unsigned i2;
            int unsigned holes;
            int unsigned fills;
            ewu_pkg::ewu_out_t want;
            items++;
            want = '0;
            if (item.restart)
            begin
                restarts++;
                alpha = load_alpha;
                beta = load_beta;
                hole_mask = '0;
                fill_mask = '0;
            end
            else
            begin
                tn = two_n();
                c1 = 32'(item.first_code);
                c2 = 32'(item.second_code);
                i1 = c1 / tn;
                i2 = c2 / tn;
                if (i1 >= tn || (c2 != 0 && i2 >= tn))
                begin
                    want.index_error = 1'b1;
                    index_errors++;
                end
                else
                begin
                    move_electron(i1, c1 % tn);
                    if (c2 != 0) move_electron(i2, c2 % tn);
                end
            end
            holes = $countones(hole_mask);
            fills = $countones(fill_mask);
            if (holes > 2 || fills > 2)
            begin
                want.class_invalid = 1'b1;
                invalid_classes++;
            end
            else
            begin
                want.exc_class = 4'(3 * holes + fills);
                classes_seen[4'(3 * holes + fills)] = 1'b1;
            end
            want.hole_count = ewu_pkg::CNT_W'(holes);
            want.virtual_count = ewu_pkg::CNT_W'(fills);
            want.alpha_occupation = alpha;
            want.beta_occupation = beta;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(ewu_pkg::ewu_out_t got);
            ewu_pkg::ewu_out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected: %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("exc_class", 64'(want.exc_class), 64'(got.exc_class));
            compare_field("class_invalid", 64'(want.class_invalid), 64'(got.class_invalid));
            compare_field("index_error", 64'(want.index_error), 64'(got.index_error));
            compare_field("hole_count", 64'(want.hole_count), 64'(got.hole_count));
            compare_field("virtual_count", 64'(want.virtual_count), 64'(got.virtual_count));
            compare_field("alpha_occupation", want.alpha_occupation, got.alpha_occupation);
            compare_field("beta_occupation", want.beta_occupation, got.beta_occupation);
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    ewu_pkg::ewu_in_t              in_data;
    logic                          out_valid;
    logic                          out_stall;
    ewu_pkg::ewu_out_t             out_data;
    logic                          cfg_we;
    logic [ewu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ewu_pkg::OCC_W-1:0]     cfg_data;

    walker_scoreboard sb;
    int burst_left;
    int seq_left;
    int stall_mode;
    int stall_left;

    int orb_tab[8]  = '{1, 64, 0, 127, 64, 4, 16, 32};
    int core_tab[8] = '{0, 64, 0, 8, 0, 1, 3, 10};
    int act_tab[8]  = '{0, 0, 64, 40, 64, 1, 5, 12};

    excitation_walker_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_item(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    function automatic logic [ewu_pkg::CODE_W-1:0] code_of(int unsigned src, int unsigned dst,
                                                          int unsigned tn);
        return ewu_pkg::CODE_W'(src * tn + dst);
    endfunction

    function automatic ewu_pkg::ewu_in_t beat_of(logic restart,
                                                 logic [ewu_pkg::CODE_W-1:0] first,
                                                 logic [ewu_pkg::CODE_W-1:0] second);
        ewu_pkg::ewu_in_t item;
        item.restart = restart;
        item.first_code = first;
        item.second_code = second;
        return item;
    endfunction

    function automatic ewu_pkg::ewu_in_t random_item(int unsigned tn);
        ewu_pkg::ewu_in_t item;
        int unsigned r;
        item = '0;
        r = $urandom_range(0, 99);
        if (seq_left == 0 || r < 5)
        begin
            item.restart = 1'b1;
            item.first_code = ewu_pkg::CODE_W'($urandom_range(0, 16383));
            item.second_code = ewu_pkg::CODE_W'($urandom_range(0, 16383));
            seq_left = $urandom_range(3, 14);
        end
        else if (r < 85)
        begin
            item.first_code = code_of($urandom_range(0, tn - 1), $urandom_range(0, tn - 1), tn);
            if ($urandom_range(0, 9) >= 4)
                item.second_code = code_of($urandom_range(0, tn - 1),
                                           $urandom_range(0, tn - 1), tn);
            seq_left--;
        end
        else
        begin
            item.first_code = ewu_pkg::CODE_W'($urandom_range(0, 16383));
            item.second_code = ewu_pkg::CODE_W'($urandom_range(0, 16383));
            seq_left--;
        end
        return item;
    endfunction

    task automatic write_reg(input logic [ewu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ewu_pkg::OCC_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input int orb, input int core, input int act,
                             input logic [ewu_pkg::OCC_W-1:0] a,
                             input logic [ewu_pkg::OCC_W-1:0] b);
        write_reg(ewu_pkg::REG_ORBITAL_COUNT, ewu_pkg::OCC_W'(orb));
        write_reg(ewu_pkg::REG_CORE_COUNT, ewu_pkg::OCC_W'(core));
        write_reg(ewu_pkg::REG_ACTIVE_COUNT, ewu_pkg::OCC_W'(act));
        write_reg(ewu_pkg::REG_START_ALPHA, a);
        write_reg(ewu_pkg::REG_START_BETA, b);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input ewu_pkg::ewu_in_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int unsigned tn;
        int orb;
        int core;
        int act;
        logic [ewu_pkg::OCC_W-1:0] a;
        logic [ewu_pkg::OCC_W-1:0] b;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        seq_left = 0;
        stall_mode = 0;
        stall_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(beat_of(1'b1, '0, '0));
        send_beat(beat_of(1'b0, 14'h3FFF, '0));
        send_beat(beat_of(1'b0, '0, 14'h3FFF));
        send_beat(beat_of(1'b0, code_of(1, 126, 128), code_of(126, 1, 128)));
        drain();

        configure(8, 2, 4, 64'h3, 64'h3);
        send_beat(beat_of(1'b1, '0, '0));
        send_beat(beat_of(1'b0, code_of(0, 12, 16), '0));
        send_beat(beat_of(1'b0, code_of(1, 13, 16), code_of(2, 14, 16)));
        send_beat(beat_of(1'b0, code_of(12, 0, 16), '0));
        send_beat(beat_of(1'b0, code_of(16, 0, 16), '0));
        send_beat(beat_of(1'b0, code_of(3, 5, 16), 14'h3FFF));
        send_beat(beat_of(1'b0, '0, code_of(13, 1, 16)));
        send_beat(beat_of(1'b1, 14'h3FFF, 14'h3FFF));
        send_beat(beat_of(1'b0, code_of(15, 15, 16), code_of(5, 5, 16)));
        send_beat(beat_of(1'b0, code_of(14, 2, 16), code_of(3, 0, 16)));
        send_beat(beat_of(1'b1, code_of(2, 3, 16), '0));
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase < 8)
            begin
                orb = orb_tab[phase];
                core = core_tab[phase];
                act = act_tab[phase];
            end
            else
            begin
                orb = $urandom_range(1, 64);
                core = $urandom_range(0, orb);
                act = $urandom_range(0, 64);
            end
            if (phase == 0)
            begin
                a = '0;
                b = '0;
            end
            else if (phase == 1)
            begin
                a = '1;
                b = '1;
            end
            else
            begin
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
            end
            configure(orb, core, act, a, b);
            tn = sb.two_n();
            seq_left = 0;
            repeat (160) send_beat(random_item(tn));
            drain();
        end

        $display("Ran %0d items over 12 register settings: %0d restarts, %0d index errors, %0d %s",
                 sb.items, sb.restarts, sb.index_errors, sb.invalid_classes,
                 "invalid classes");
        $display("Checked %0d result beats; class codes reached (bit per code): %b",
                 sb.checked, sb.classes_seen);
        if (sb.errors == 0)
            $display("excitation_walker_update test passed");
        else
            $display("excitation_walker_update test failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("excitation_walker_update test failed");
        $finish;
    end

endmodule
